// ===== hdl/flow_sequence_reorder_tracker_macros.svh =====
// assertion macros used by the flow sequence reorder tracker checker
// no dependencies; every macro samples on posedge clock and is held off during reset
`ifndef FLOW_SEQUENCE_REORDER_TRACKER_MACROS_SVH
`define FLOW_SEQUENCE_REORDER_TRACKER_MACROS_SVH

// same-cycle implication
`define FSRT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FSRT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/fsrt_pkg.sv =====
// shared types and constants for the flow sequence reorder tracker
// no dependencies; imported by the top level, fsrt_entry_eval and fsrt_checker
`default_nettype none
package fsrt_pkg;

   localparam int ADDR_W    = 32;
   localparam int PORT_W    = 16;
   localparam int SEQ_W     = 32;
   localparam int TIME_W    = 32;
   localparam int KEY_W     = ADDR_W + PORT_W;
   localparam int EXPIRY_W  = 16;
   localparam int STATUS_W  = 3;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 72;

   localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 16'd120;

   // result codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_NEW        = 3'd0,
      STATUS_RESTART    = 3'd1,
      STATUS_ADVANCE    = 3'd2,
      STATUS_DUPLICATE  = 3'd3,
      STATUS_OUT_OF_ORDER = 3'd4,
      STATUS_FULL       = 3'd5
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_DECIDE
   } state_type;

   // one stored flow entry
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [SEQ_W-1:0]  max_sequence;
      logic [TIME_W-1:0] last_seen;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // per-entry compare results
   typedef struct packed {
      logic match;
      logic expired;
   } eval_type;

endpackage
`default_nettype wire

// ===== hdl/flow_sequence_reorder_tracker.sv =====
// top level of the flow sequence reorder tracker: sequencer, output register, config register
// depends on fsrt_pkg, fsrt_ram and fsrt_entry_eval
//
// Tracks client flows keyed by source address and port in a table of TABLE_ENTRIES
// entries held in one single-port-read ram. Flows are allocated in ascending slot order
// and never released, so the occupied slots are always 0 to fill-1 and a fill counter
// replaces per-entry valid bits; no clearing pass is needed after reset. Each request is
// looked up by walking the occupied slots one ram read per cycle, stopping at the first
// key match. A request takes longer as fill grows (less on an early hit); the single ram
// read port walked by the sequencer sets how long it takes. A new
// request is taken while the previous result still waits on rsp_tready.
`default_nettype none
module flow_sequence_reorder_tracker
   import fsrt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request: [31:0] source_address, [47:32] source_port,
   //          [79:48] seq_number, [111:80] now_seconds
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // response: [2:0] flow_status, [34:3] previous_maximum,
   //           [66:35] stored_maximum, [71:67] zero
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // expiry_seconds register write
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [EXPIRY_W-1:0]   csr_data
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

   // sequencer state
   state_type          state_ff, state_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      pend_idx_ff, pend_idx_in;
   logic               hit_ff, hit_in;
   logic [AW-1:0]      hit_idx_ff, hit_idx_in;
   logic               hit_expired_ff, hit_expired_in;
   logic [SEQ_W-1:0]   hit_max_ff, hit_max_in;
   logic               stale_ff, stale_in;
   logic [AW-1:0]      stale_idx_ff, stale_idx_in;

   // request fields held during the walk
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [TIME_W-1:0]  now_ff, now_in;

   // config and output registers
   logic [EXPIRY_W-1:0] expiry_ff, expiry_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // ram ports
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   entry_type          wr_entry;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          rd_entry;
   eval_type           eval;

   // decide-stage values
   logic               out_free;
   status_type         status;
   logic [SEQ_W-1:0]   prior_max;
   logic [SEQ_W-1:0]   new_max;

   fsrt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry = entry_type'(rd_data);

   fsrt_entry_eval u_eval (
      .entry          (rd_entry),
      .key            (key_ff),
      .now_seconds    (now_ff),
      .expiry_seconds (expiry_ff),
      .result         (eval)
   );

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         expiry_ff    <= EXPIRY_RESET;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         expiry_ff    <= expiry_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      issue_ff       <= issue_in;
      pend_idx_ff    <= pend_idx_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      hit_expired_ff <= hit_expired_in;
      hit_max_ff     <= hit_max_in;
      stale_ff       <= stale_in;
      stale_idx_ff   <= stale_idx_in;
      key_ff         <= key_in;
      seq_ff         <= seq_in;
      now_ff         <= now_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // config register write
   assign csr_ready = 1'b1;
   always_comb begin
      expiry_in = expiry_ff;
      if (csr_valid) begin
         expiry_in = csr_data;
      end
   end

   // decide-stage result from the walk
   always_comb begin
      prior_max = '0;
      new_max   = '0;
      status    = STATUS_FULL;
      if (hit_ff) begin
         prior_max = hit_max_ff;
         new_max   = hit_max_ff;
         if (hit_expired_ff) begin
            status  = STATUS_RESTART;
            new_max = seq_ff;
         end else if (seq_ff < hit_max_ff) begin
            status = STATUS_OUT_OF_ORDER;
         end else if (seq_ff > hit_max_ff) begin
            status  = STATUS_ADVANCE;
            new_max = seq_ff;
         end else begin
            status = STATUS_DUPLICATE;
         end
      end else if (fill_ff != FULL_COUNT || stale_ff) begin
         status  = STATUS_NEW;
         new_max = seq_ff;
      end
   end

   // sequencer: next state, ram access and output register
   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      issue_in       = issue_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_expired_in = hit_expired_ff;
      hit_max_in     = hit_max_ff;
      stale_in       = stale_ff;
      stale_idx_in   = stale_idx_ff;
      key_in         = key_ff;
      seq_in         = seq_ff;
      now_in         = now_ff;
      rd_en          = 1'b0;
      rd_addr        = issue_ff[AW-1:0];
      wr_en          = 1'b0;
      wr_addr        = hit_idx_ff;
      wr_entry       = '{key: key_ff, max_sequence: new_max, last_seen: now_ff};
      req_tready     = 1'b0;
      out_free       = !rsp_valid_ff || rsp_tready;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         STATE_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               key_in   = {req_tdata[31:0], req_tdata[47:32]};
               seq_in   = req_tdata[79:48];
               now_in   = req_tdata[111:80];
               issue_in = '0;
               hit_in   = 1'b0;
               stale_in = 1'b0;
               state_in = STATE_SCAN;
            end
         end
         STATE_SCAN: begin
            // issue the next occupied slot
            if (issue_ff != fill_ff) begin
               rd_en       = 1'b1;
               issue_in    = issue_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[AW-1:0];
            end
            // examine the slot read last cycle
            if (pend_ff) begin
               if (eval.match) begin
                  hit_in         = 1'b1;
                  hit_idx_in     = pend_idx_ff;
                  hit_expired_in = eval.expired;
                  hit_max_in     = rd_entry.max_sequence;
                  pend_in        = 1'b0;
                  state_in       = STATE_DECIDE;
               end else if (eval.expired && !stale_ff) begin
                  stale_in     = 1'b1;
                  stale_idx_in = pend_idx_ff;
               end
            end else if (issue_ff == fill_ff) begin
               state_in = STATE_DECIDE;
            end
         end
         STATE_DECIDE: begin
            if (out_free) begin
               if (hit_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = hit_idx_ff;
               end else if (fill_ff != FULL_COUNT) begin
                  wr_en   = 1'b1;
                  wr_addr = fill_ff[AW-1:0];
                  fill_in = fill_ff + CW'(1);
               end else if (stale_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = stale_idx_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, new_max, prior_max, status};
               state_in     = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== hdl/fsrt_ram.sv =====
// generic single-write, single-read ram with a registered read port
// depends on nothing
`default_nettype none
module fsrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/fsrt_entry_eval.sv =====
// key match and idle expiry test of one stored flow entry
// depends on fsrt_pkg
`default_nettype none
module fsrt_entry_eval
   import fsrt_pkg::*;
(
   input  wire entry_type             entry,
   input  wire logic [KEY_W-1:0]      key,
   input  wire logic [TIME_W-1:0]     now_seconds,
   input  wire logic [EXPIRY_W-1:0]   expiry_seconds,
   output      eval_type              result
);

   logic [TIME_W-1:0] idle_time;

   // wrapping idle time, expired when strictly past the limit
   always_comb begin
      idle_time      = now_seconds - entry.last_seen;
      result.match   = (entry.key == key);
      result.expired = (idle_time > {{(TIME_W-EXPIRY_W){1'b0}}, expiry_seconds});
   end

endmodule
`default_nettype wire

// ===== hdl/fsrt_checker.sv =====
// port-level checks of the flow sequence reorder tracker, bound to the top level
// depends on fsrt_pkg and flow_sequence_reorder_tracker_macros.svh
`default_nettype none
`include "flow_sequence_reorder_tracker_macros.svh"
module fsrt_checker
   import fsrt_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [STATUS_W-1:0] rsp_status;
   logic [SEQ_W-1:0]    rsp_prev;
   logic [SEQ_W-1:0]    rsp_stored;
   logic [4:0]          rsp_pad;
   logic                rsp_code_ok;
   logic                rsp_zero;
   logic                rsp_is_full;
   logic                rsp_is_new;
   logic                rsp_is_hit;
   logic                rsp_order_ok;

   assign rsp_status = rsp_tdata[2:0];
   assign rsp_prev   = rsp_tdata[34:3];
   assign rsp_stored = rsp_tdata[66:35];
   assign rsp_pad    = rsp_tdata[71:67];

   // decoded views of the response transfer
   assign rsp_code_ok  = (rsp_status <= STATUS_FULL) && (rsp_pad == '0);
   assign rsp_zero     = (rsp_prev == '0) && (rsp_stored == '0);
   assign rsp_is_full  = rsp_tvalid && (rsp_status == STATUS_FULL);
   assign rsp_is_new   = rsp_tvalid && (rsp_status == STATUS_NEW);
   assign rsp_is_hit   = rsp_tvalid && (rsp_status == STATUS_DUPLICATE ||
                                        rsp_status == STATUS_OUT_OF_ORDER ||
                                        rsp_status == STATUS_ADVANCE);
   assign rsp_order_ok = (rsp_status == STATUS_ADVANCE) ? (rsp_stored > rsp_prev)
                                                        : (rsp_stored == rsp_prev);

   // a stalled response stays offered
   `FSRT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "response dropped while stalled")

   // only defined result codes and zero padding leave the block
   `FSRT_ASSERT_NOW(a_status_code, rsp_tvalid, rsp_code_ok, "undefined flow status or padding")

   // a full table stores nothing and reports zeros
   `FSRT_ASSERT_NOW(a_full_zero, rsp_is_full, rsp_zero, "table full result not zero")

   // a new flow has no previous maximum
   `FSRT_ASSERT_NOW(a_new_prev, rsp_is_new, rsp_prev == '0, "new flow with previous maximum")

   // an advance raises the maximum, a duplicate or reorder keeps it
   `FSRT_ASSERT_NOW(a_max_order, rsp_is_hit, rsp_order_ok, "stored maximum inconsistent with status")

endmodule

bind flow_sequence_reorder_tracker fsrt_checker u_fsrt_checker (.*);
`default_nettype wire
